// ===== rtl/sfr_pkg.sv =====
// Shared types, codes and constants for the serial frame receiver.
// Used by every module of the block; depends on nothing.
package sfr_pkg;

   // Width of the acknowledge timer.
   localparam int TIMER_WIDTH = 16;
   localparam int TIMEOUT_WIDTH = 16;
   localparam int CMP_WIDTH = (TIMER_WIDTH > TIMEOUT_WIDTH) ? TIMER_WIDTH : TIMEOUT_WIDTH;
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 16'd1000;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Request type codes.
   localparam logic [1:0] REQ_BYTE = 2'd0;
   localparam logic [1:0] REQ_TICK = 2'd1;
   localparam logic [1:0] REQ_SENT = 2'd2;

   // Operation codes carried through the queue.
   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_SENT = 2'd2;

   // Result event codes.
   localparam logic [1:0] EV_DATA  = 2'd0;
   localparam logic [1:0] EV_END   = 2'd1;
   localparam logic [1:0] EV_ACK   = 2'd2;
   localparam logic [1:0] EV_RETRY = 2'd3;

   // Special byte values.
   localparam logic [7:0] BYTE_START = 8'hff;
   localparam logic [7:0] BYTE_SYNC  = 8'hdd;
   localparam logic [7:0] BYTE_ACKHD = 8'hfd;
   localparam logic [7:0] BYTE_ACK   = 8'h02;
   localparam logic [7:0] BYTE_NAK   = 8'h03;
   localparam logic [7:0] RETRY_MAX  = 8'hff;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [7:0] msg_code;
      logic [7:0] data_byte;
      logic [7:0] retry_count;
   } rsp_payload_type;

   // A classified request as it waits in the queue.
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
      logic       is_start;
      logic       is_sync;
      logic       is_ackhd;
      logic       is_ack;
      logic       is_nak;
      logic       is_zero;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== rtl/serial_frame_receiver_with_ack_retry.sv =====
// A request accepted at a clock edge goes into the queue, and its result, if any, is
// registered in the back's output register before it appears on rsp_.
// Throughput: one request per cycle while rsp_ is not stalled, set by the back's parser.
// A four-entry queue lets requests keep arriving while a result waits on rsp_stall.
// Reset (synchronous, active high) clears the parser, timer, retry count, queue and output,
// and loads the retry timeout with 1000 ticks; there is no clearing pass.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
module serial_frame_receiver_with_ack_retry (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sfr_pkg::req_payload_type      req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sfr_pkg::rsp_payload_type      rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sfr_pkg::TIMEOUT_WIDTH-1:0] csr_data
);

   // The front decodes each request into an operation and precomputes the
   // byte comparisons the parser needs. Unused request types are accepted
   // and dropped without reaching the queue.
   sfr_pkg::q_status_type q_status;
   sfr_pkg::entry_type    push_entry;
   sfr_pkg::entry_type    head_entry;
   logic                  push;
   logic                  pop;

   sfr_front u_front (
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   // The queue decouples the two sides: the front stalls only when it is
   // full, which happens only after rsp_stall has held the back for a while.
   sfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   // The back holds all protocol state. It takes one queued request per cycle
   // whenever its output register is free or being emptied in the same cycle.
   // While a result waits on rsp_stall, every request stays in the queue.
   sfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .head_entry  (head_entry),
      .pop         (pop),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/sfr_front.sv =====
// Front part of the serial frame receiver: accepts requests and classifies them.
// Depends on sfr_pkg.
module sfr_front (
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  sfr_pkg::req_payload_type req_payload,
   input  sfr_pkg::q_status_type   q_status,
   output logic                    push,
   output sfr_pkg::entry_type      push_entry
);

   logic accept;
   logic known;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   always_comb begin
      push_entry.rx_byte  = req_payload.rx_byte;
      push_entry.is_start = (req_payload.rx_byte == sfr_pkg::BYTE_START);
      push_entry.is_sync  = (req_payload.rx_byte == sfr_pkg::BYTE_SYNC);
      push_entry.is_ackhd = (req_payload.rx_byte == sfr_pkg::BYTE_ACKHD);
      push_entry.is_ack   = (req_payload.rx_byte == sfr_pkg::BYTE_ACK);
      push_entry.is_nak   = (req_payload.rx_byte == sfr_pkg::BYTE_NAK);
      push_entry.is_zero  = (req_payload.rx_byte == 8'd0);
      known = 1'b1;
      case (req_payload.req_type)
         sfr_pkg::REQ_BYTE: push_entry.op = sfr_pkg::OP_BYTE;
         sfr_pkg::REQ_TICK: push_entry.op = sfr_pkg::OP_TICK;
         sfr_pkg::REQ_SENT: push_entry.op = sfr_pkg::OP_SENT;
         default: begin
            // The unused request type has no effect and is dropped here.
            push_entry.op = sfr_pkg::OP_BYTE;
            known = 1'b0;
         end
      endcase
   end

   assign push = accept && known && !reset;

endmodule

// ===== rtl/sfr_queue.sv =====
// Short register queue between the front and back of the frame receiver.
// Depends on sfr_pkg.
module sfr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sfr_pkg::entry_type    push_entry,
   input  logic                  pop,
   output sfr_pkg::entry_type    head_entry,
   output sfr_pkg::q_status_type q_status
);

   sfr_pkg::entry_type                    store_ff [sfr_pkg::QUEUE_DEPTH];
   logic [sfr_pkg::QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [sfr_pkg::QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [sfr_pkg::QUEUE_CNT_WIDTH-1:0]   count_ff, count_in;
   logic                                  do_push;
   logic                                  do_pop;

   assign q_status.full  = (count_ff == sfr_pkg::QUEUE_CNT_WIDTH'(sfr_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign head_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sfr_pkg::QUEUE_PTR_WIDTH'(sfr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sfr_pkg::QUEUE_PTR_WIDTH'(sfr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/sfr_back.sv =====
// Back part of the frame receiver: frame parser, acknowledge timer and result register.
// Depends on sfr_pkg.
module sfr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  sfr_pkg::q_status_type         q_status,
   input  sfr_pkg::entry_type            head_entry,
   output logic                          pop,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sfr_pkg::TIMEOUT_WIDTH-1:0] csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sfr_pkg::rsp_payload_type      rsp_payload
);

   localparam logic [2:0] PH_HUNT   = 3'd0;
   localparam logic [2:0] PH_GOT_FF = 3'd1;
   localparam logic [2:0] PH_GOT_FD = 3'd2;
   localparam logic [2:0] PH_CODE   = 3'd3;
   localparam logic [2:0] PH_LEN    = 3'd4;
   localparam logic [2:0] PH_BODY   = 3'd5;

   logic [2:0]                        phase_ff, phase_in;
   logic                              waiting_ff, waiting_in;
   logic [sfr_pkg::TIMER_WIDTH-1:0]   elapsed_ff, elapsed_in;
   logic [7:0]                        retries_ff, retries_in;
   logic [7:0]                        code_ff, code_in;
   logic [7:0]                        left_ff, left_in;
   logic [sfr_pkg::TIMEOUT_WIDTH-1:0] timeout_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   sfr_pkg::rsp_payload_type          rsp_payload_ff, rsp_payload_in;

   logic                              emit;
   logic [2:0]                        start_phase;
   logic [7:0]                        retries_inc;
   logic [sfr_pkg::TIMER_WIDTH-1:0]   elapsed_inc;

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign pop = !q_status.empty && (!rsp_valid_ff || !rsp_stall);

   // Restart the scan on the current byte.
   assign start_phase = head_entry.is_start ? PH_GOT_FF :
                        head_entry.is_ackhd ? PH_GOT_FD : PH_HUNT;
   assign retries_inc = (retries_ff == sfr_pkg::RETRY_MAX) ? retries_ff : retries_ff + 8'd1;
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;

   always_comb begin
      phase_in   = phase_ff;
      waiting_in = waiting_ff;
      elapsed_in = elapsed_ff;
      retries_in = retries_ff;
      code_in    = code_ff;
      left_in    = left_ff;
      emit       = 1'b0;
      rsp_payload_in.event_res = sfr_pkg::EV_DATA;
      rsp_payload_in.msg_code  = 8'd0;
      rsp_payload_in.data_byte = 8'd0;
      case (head_entry.op)
         sfr_pkg::OP_BYTE: begin
            case (phase_ff)
               PH_GOT_FF: begin
                  phase_in = head_entry.is_sync ? PH_CODE : start_phase;
               end
               PH_GOT_FD: begin
                  if (waiting_ff && head_entry.is_ack) begin
                     waiting_in = 1'b0;
                     retries_in = 8'd0;
                     elapsed_in = '0;
                     phase_in   = PH_HUNT;
                     emit       = 1'b1;
                     rsp_payload_in.event_res = sfr_pkg::EV_ACK;
                  end else if (waiting_ff && head_entry.is_nak) begin
                     retries_in = retries_inc;
                     elapsed_in = '0;
                     phase_in   = PH_HUNT;
                     emit       = 1'b1;
                     rsp_payload_in.event_res = sfr_pkg::EV_RETRY;
                  end else begin
                     phase_in = start_phase;
                  end
               end
               PH_CODE: begin
                  code_in  = head_entry.rx_byte;
                  phase_in = PH_LEN;
               end
               PH_LEN: begin
                  if (head_entry.is_zero) begin
                     phase_in = PH_HUNT;
                  end else begin
                     left_in  = head_entry.rx_byte;
                     phase_in = PH_BODY;
                  end
               end
               PH_BODY: begin
                  emit = 1'b1;
                  rsp_payload_in.msg_code  = code_ff;
                  rsp_payload_in.data_byte = head_entry.rx_byte;
                  if (left_ff <= 8'd1) begin
                     left_in  = 8'd0;
                     phase_in = PH_HUNT;
                     rsp_payload_in.event_res = sfr_pkg::EV_END;
                  end else begin
                     left_in = left_ff - 8'd1;
                  end
               end
               default: begin
                  phase_in = start_phase;
               end
            endcase
         end
         sfr_pkg::OP_TICK: begin
            if (waiting_ff) begin
               if (sfr_pkg::CMP_WIDTH'(elapsed_inc) >= sfr_pkg::CMP_WIDTH'(timeout_ff)) begin
                  retries_in = retries_inc;
                  elapsed_in = '0;
                  emit       = 1'b1;
                  rsp_payload_in.event_res = sfr_pkg::EV_RETRY;
               end else begin
                  elapsed_in = elapsed_inc;
               end
            end
         end
         sfr_pkg::OP_SENT: begin
            waiting_in = 1'b1;
            elapsed_in = '0;
            retries_in = 8'd0;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
      rsp_payload_in.retry_count = retries_in;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         waiting_ff   <= 1'b0;
         elapsed_ff   <= '0;
         retries_ff   <= 8'd0;
         code_ff      <= 8'd0;
         left_ff      <= 8'd0;
         timeout_ff   <= sfr_pkg::TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff   <= phase_in;
            waiting_ff <= waiting_in;
            elapsed_ff <= elapsed_in;
            retries_ff <= retries_in;
            code_ff    <= code_in;
            left_ff    <= left_in;
         end
         if (csr_valid) begin
            timeout_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

// ===== bench/frame_event_checker.sv =====
`timescale 1ns / 1ps
// Checker for the serial frame receiver: it predicts the events of every accepted request
// and compares each delivered result with the oldest prediction.
// Depends on sfr_pkg for the payload types, event codes and special bytes.
module frame_event_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  sfr_pkg::req_payload_type          req_payload,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  sfr_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [sfr_pkg::TIMEOUT_WIDTH-1:0] csr_data,
   output int                                mismatch_count,
   output int                                pending
);
   import sfr_pkg::*;

   typedef enum logic [2:0] {
      HUNT, GOT_START, GOT_ACKHD, GET_CODE, GET_LEN, GET_BODY
   } scan_phase_type;

   scan_phase_type phase;
   logic waiting;
   logic [TIMER_WIDTH-1:0] elapsed;
   logic [7:0] retries;
   logic [7:0] code;
   logic [7:0] left;
   logic [TIMEOUT_WIDTH-1:0] timeout;
   rsp_payload_type expected_events[$];
   rsp_payload_type want;
   int errors_seen = 0;

   function automatic scan_phase_type phase_after(input logic [7:0] b);
      if (b == BYTE_START) return GOT_START;
      if (b == BYTE_ACKHD) return GOT_ACKHD;
      return HUNT;
   endfunction

   function automatic void expect_event(input logic [1:0] ev, input logic [7:0] c,
                                        input logic [7:0] d);
      rsp_payload_type e;
      e.event_res = ev;
      e.msg_code = c;
      e.data_byte = d;
      e.retry_count = retries;
      expected_events.push_back(e);
   endfunction

   function automatic void count_retry();
      if (retries != RETRY_MAX) retries++;
      elapsed = '0;
   endfunction

   function automatic void predict_events(input req_payload_type r);
      case (r.req_type)
         REQ_BYTE: begin
            case (phase)
               GOT_START: phase = (r.rx_byte == BYTE_SYNC) ? GET_CODE : phase_after(r.rx_byte);
               GOT_ACKHD: begin
                  if (waiting && r.rx_byte == BYTE_ACK) begin
                     waiting = 1'b0;
                     retries = '0;
                     elapsed = '0;
                     phase = HUNT;
                     expect_event(EV_ACK, 8'h00, 8'h00);
                  end else if (waiting && r.rx_byte == BYTE_NAK) begin
                     count_retry();
                     phase = HUNT;
                     expect_event(EV_RETRY, 8'h00, 8'h00);
                  end else begin
                     phase = phase_after(r.rx_byte);
                  end
               end
               GET_CODE: begin
                  code = r.rx_byte;
                  phase = GET_LEN;
               end
               GET_LEN: begin
                  if (r.rx_byte == 8'h00) begin
                     phase = HUNT;
                  end else begin
                     left = r.rx_byte;
                     phase = GET_BODY;
                  end
               end
               GET_BODY: begin
                  if (left <= 8'd1) begin
                     left = '0;
                     phase = HUNT;
                     expect_event(EV_END, code, r.rx_byte);
                  end else begin
                     left--;
                     expect_event(EV_DATA, code, r.rx_byte);
                  end
               end
               default: phase = phase_after(r.rx_byte);
            endcase
         end
         REQ_TICK: begin
            if (waiting) begin
               if (elapsed != {TIMER_WIDTH{1'b1}}) elapsed++;
               if (elapsed >= timeout) begin
                  count_retry();
                  expect_event(EV_RETRY, 8'h00, 8'h00);
               end
            end
         end
         REQ_SENT: begin
            waiting = 1'b1;
            elapsed = '0;
            retries = '0;
         end
         default: ;
      endcase
   endfunction

   // Results are checked before the request of the same edge is predicted; a request
   // never yields its result at the edge where it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         phase = HUNT;
         waiting = 1'b0;
         elapsed = '0;
         retries = '0;
         code = '0;
         left = '0;
         timeout = TIMEOUT_RESET;
         expected_events.delete();
      end else begin
         if (csr_valid && csr_ready) timeout = csr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               errors_seen++;
               $display("%0t: result with none expected: event %0d code %h data %h retries %0d",
                        $time, rsp_payload.event_res, rsp_payload.msg_code,
                        rsp_payload.data_byte, rsp_payload.retry_count);
            end else begin
               want = expected_events.pop_front();
               if (rsp_payload.event_res !== want.event_res) begin
                  errors_seen++;
                  $display("%0t: event_res expected %0d actual %0d",
                           $time, want.event_res, rsp_payload.event_res);
               end
               if (rsp_payload.msg_code !== want.msg_code) begin
                  errors_seen++;
                  $display("%0t: msg_code expected %h actual %h",
                           $time, want.msg_code, rsp_payload.msg_code);
               end
               if (rsp_payload.data_byte !== want.data_byte) begin
                  errors_seen++;
                  $display("%0t: data_byte expected %h actual %h",
                           $time, want.data_byte, rsp_payload.data_byte);
               end
               if (rsp_payload.retry_count !== want.retry_count) begin
                  errors_seen++;
                  $display("%0t: retry_count expected %0d actual %0d",
                           $time, want.retry_count, rsp_payload.retry_count);
               end
            end
         end
         if (req_valid && !req_stall) predict_events(req_payload);
      end
      pending <= expected_events.size();
      mismatch_count <= errors_seen;
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the serial frame receiver testbench: clock, reset, request stimulus, the
// result-side stall pattern and the verdict. Depends on sfr_pkg, frame_event_checker and the block.
module tb_top;
   import sfr_pkg::*;

   // The request type that the block must ignore.
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   // Length of the long hold-off on the result side.
   localparam int HOLD_CYCLES = 80;
   // Cycles to let pass once no result is expected, for the queue and result registers and a
   // four-entry queue that may still hold requests that give no result.
   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_LIMIT = 5000;
   localparam int PHASE_REQUESTS = 65;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [TIMEOUT_WIDTH-1:0] csr_data = '0;

   int mismatch_count;
   int pending;

   // Sender state: requests left in the current burst, requests accepted so far, and
   // a switch that turns the gaps off.
   int burst_left = 0;
   int req_count = 0;
   bit steady_offer = 1'b0;

   // Receiver state. The stimulus asks for a long hold-off by bumping hold_token;
   // the receiver notices the change and counts the hold-off down on its own.
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   logic [1:0] stall_mode = '0;
   int mode_left = 0;

   always #4 clock = ~clock;

   serial_frame_receiver_with_ack_retry uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   frame_event_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending        (pending)
   );

   // The receiver switches between stall patterns at random intervals: never
   // stalling, stalling now and then, stalling most of the time, and alternating.
   // A requested hold-off overrides the pattern until hold_left, loaded from HOLD_CYCLES, runs down.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            mode_left <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // Offers one request and returns at the edge where it is accepted, with valid
   // still high. Valid only drops when a gap follows, so it is never lowered and raised
   // within one time step.
   task automatic send_req(input logic [1:0] kind, input logic [7:0] value);
      int gap;
      if (!steady_offer && burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // Now and then a long burst gives a stretch with no idling at all.
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      if (burst_left != 0) burst_left--;
      req_payload <= '{req_type: kind, rx_byte: value};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_count++;
   endtask

   task automatic send_byte(input logic [7:0] value);
      send_req(REQ_BYTE, value);
   endtask

   // Stops offering requests, waits until every expected result has come out or the
   // DRAIN_LIMIT wait runs out, and lets the block settle, so that the retry timeout may be written.
   task automatic wait_idle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_WIDTH-1:0] value);
      wait_idle();
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // One random sequence. The largest share are well-formed frames with random content, so that
   // the parser gets deep into the body; the rest are message-sent events, ticks,
   // acknowledge pairs, broken pairs, cut-off frames and plain noise.
   task automatic random_sequence();
      int pick;
      int len;
      int cut;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         cut = $urandom_range(0, 99);
         if (cut < 2) len = $urandom_range(9, 24);
         else if (cut < 8) len = 0;
         else len = $urandom_range(1, 8);
         send_byte(BYTE_START);
         send_byte(BYTE_SYNC);
         send_byte(8'($urandom_range(0, 255)));
         send_byte(8'(len));
         repeat (len) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 55) begin
         send_req(REQ_SENT, 8'($urandom_range(0, 255)));
      end else if (pick < 70) begin
         repeat ($urandom_range(1, 6)) send_req(REQ_TICK, 8'($urandom_range(0, 255)));
      end else if (pick < 80) begin
         send_byte(BYTE_ACKHD);
         send_byte($urandom_range(0, 1) ? BYTE_ACK : BYTE_NAK);
      end else if (pick < 90) begin
         case ($urandom_range(0, 2))
            0: begin
               send_byte(BYTE_START);
               send_byte(8'($urandom_range(0, 255)));
            end
            1: begin
               send_byte(BYTE_ACKHD);
               send_byte(8'($urandom_range(0, 255)));
            end
            default: begin
               // A frame cut short: the bytes that follow are taken as its body.
               len = $urandom_range(2, 8);
               send_byte(BYTE_START);
               send_byte(BYTE_SYNC);
               send_byte(8'($urandom_range(0, 255)));
               send_byte(8'(len));
               repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom_range(0, 255)));
            end
         endcase
      end else begin
         send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      logic [TIMEOUT_WIDTH-1:0] phase_timeout[4];
      int first;
      int phase_idx;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the retry timeout at its reset value.
      // A normal frame whose payload holds the smallest and largest byte.
      send_byte(BYTE_START);
      send_byte(BYTE_SYNC);
      send_byte(8'h5a);
      send_byte(8'd3);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h7e);
      // A frame of length zero is dropped without any result.
      send_byte(BYTE_START);
      send_byte(BYTE_SYNC);
      send_byte(8'h00);
      send_byte(8'h00);
      // A start byte where the sync byte belongs is itself taken as a new start;
      // the frame after it has length one, so it gives only the end event.
      send_byte(BYTE_START);
      send_byte(BYTE_START);
      send_byte(BYTE_SYNC);
      send_byte(8'hff);
      send_byte(8'd1);
      send_byte(8'h80);
      // An acknowledge and a tick while no acknowledge is awaited do nothing.
      send_byte(BYTE_ACKHD);
      send_byte(BYTE_ACK);
      send_req(REQ_TICK, 8'h00);
      // The unused request type must not feed the start byte to the parser.
      send_req(REQ_UNUSED, BYTE_START);
      send_byte(BYTE_SYNC);
      // After a message is sent, a repeated acknowledge header is rescanned and the
      // acknowledge that follows still counts.
      send_req(REQ_SENT, 8'hff);
      send_byte(BYTE_ACKHD);
      send_byte(BYTE_ACKHD);
      send_byte(BYTE_ACK);
      // A negative acknowledge asks for a retransmission.
      send_req(REQ_SENT, 8'h00);
      send_byte(BYTE_ACKHD);
      send_byte(BYTE_NAK);

      // Timeout at reset: a few ticks stay far below it and ask for nothing.
      send_req(REQ_SENT, 8'h00);
      repeat (10) send_req(REQ_TICK, 8'($urandom_range(0, 255)));

      // Smallest timeout: every tick asks for a retransmission, and the retry count
      // runs into its ceiling.
      write_timeout(16'd1);
      send_req(REQ_SENT, 8'h00);
      repeat (int'(RETRY_MAX) + 5) send_req(REQ_TICK, 8'($urandom_range(0, 255)));

      // Random part over several timeouts.
      phase_timeout[0] = 16'd1;
      phase_timeout[1] = 16'd3;
      phase_timeout[2] = 16'($urandom_range(2, 12));
      phase_timeout[3] = 16'($urandom_range(13, 60));
      for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
         write_timeout(phase_timeout[phase_idx]);
         if (phase_idx == 1) begin
            // Hold the result side off while a long frame is offered without gaps,
            // so that the block fills up and has to stall its request side.
            steady_offer = 1'b1;
            hold_token <= hold_token + 1;
            send_byte(BYTE_START);
            send_byte(BYTE_SYNC);
            send_byte(8'h33);
            send_byte(8'd40);
            repeat (40) send_byte(8'($urandom_range(0, 255)));
            steady_offer = 1'b0;
         end
         first = req_count;
         while (req_count - first < PHASE_REQUESTS) random_sequence();
      end

      wait_idle();
      if (mismatch_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
         $display("Some tests failed");
      end
      $finish;
   end

   // The slowest correct run takes well under a quarter of a millisecond.
   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== serial_frame_receiver_with_ack_retry.f =====
rtl/sfr_pkg.sv
rtl/sfr_front.sv
rtl/sfr_queue.sv
rtl/sfr_back.sv
rtl/serial_frame_receiver_with_ack_retry.sv
bench/frame_event_checker.sv
bench/tb_top.sv
